/* hdl/playfair_digraph_encrypt_unit_macros.svh */
// assertion helpers shared by the playfair block
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_MACROS_SVH

// property checked on every rising edge outside reset
`define PFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define PFE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hdl/pfe_pkg.sv */
package pfe_pkg;

  typedef logic [4:0] code_t;
  typedef logic [2:0] idx_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
  } pos_t;

  localparam int NUM_ROWS   = 5;
  localparam int NUM_COLS   = 5;
  localparam int ROW_WIDTH  = 25;
  localparam int CELL_WIDTH = 5;

  localparam code_t CODE_I = 5'd8;
  localparam code_t CODE_J = 5'd9;
  localparam code_t CODE_Q = 5'd16;
  localparam code_t CODE_X = 5'd23;
  localparam code_t CODE_Z = 5'd25;

  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_LOWER_Z = 8'd122;

  localparam logic [2:0] REG_SQUARE_ROW_ZERO  = 3'd0;
  localparam logic [2:0] REG_SQUARE_ROW_ONE   = 3'd1;
  localparam logic [2:0] REG_SQUARE_ROW_TWO   = 3'd2;
  localparam logic [2:0] REG_SQUARE_ROW_THREE = 3'd3;
  localparam logic [2:0] REG_SQUARE_ROW_FOUR  = 3'd4;

endpackage

/* hdl/playfair_digraph_encrypt_unit.sv */
// a pair is held in the work registers, then loaded into the result buffer
// throughput: one byte per cycle unless a formed pair waits on a full buffer;
//   the result buffer drains one letter per cycle while cipher_ready is high
// a doubled letter with end of message gives two pairs
// reset: synchronous, clears key square, held letter, work valid flag and buffer length
`include "playfair_digraph_encrypt_unit_macros.svh"

module playfair_digraph_encrypt_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        plain_valid,
  output logic        plain_ready,
  input  logic [7:0]  plain_byte,
  input  logic        end_of_message,
  output logic        cipher_valid,
  input  logic        cipher_ready,
  output logic [6:0]  cipher_byte,
  output logic        last_of_run
);
  import pfe_pkg::*;

  logic [ROW_WIDTH-1:0] square_row [NUM_ROWS];

  code_t held_letter, held_letter_next;
  logic  held_valid, held_valid_next;

  logic  work_valid;
  logic  work_twice;
  code_t work_first, work_second;

  logic [6:0] buf_data [4];
  logic [2:0] buf_len;

  logic  plain_xfer, cipher_xfer, work_move, buf_free;
  logic  is_letter;
  code_t letter;
  logic  pair_now, twice_now;
  code_t first_now, second_now;
  pos_t  p1, p2;
  code_t o1, o2;
  logic [2:0] reg_idx;
  logic  cipher_in_range;

  function automatic code_t filler_for(code_t c);
    return (c == CODE_X) ? CODE_Q : CODE_X;
  endfunction

  function automatic idx_t inc5(idx_t x);
    return (x == idx_t'(NUM_COLS - 1)) ? '0 : idx_t'(x + 3'd1);
  endfunction

  function automatic logic [6:0] to_ascii(code_t c);
    logic [6:0] a;
    a = (c > CODE_Z) ? ASCII_LOWER_Z[6:0] : 7'(ASCII_LOWER_A[6:0] + {2'b00, c});
    return a;
  endfunction

  function automatic code_t cell_at(logic [ROW_WIDTH-1:0] sq [NUM_ROWS], idx_t r, idx_t c);
    logic [ROW_WIDTH-1:0] rowv;
    rowv = sq[r];
    return rowv[CELL_WIDTH*c +: CELL_WIDTH];
  endfunction

  function automatic pos_t locate(logic [ROW_WIDTH-1:0] sq [NUM_ROWS], code_t c);
    pos_t p;
    p = '0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      for (int k = NUM_COLS - 1; k >= 0; k--) begin
        if (sq[r][CELL_WIDTH*k +: CELL_WIDTH] == c) begin
          p.row = idx_t'(r);
          p.col = idx_t'(k);
        end
      end
    end
    return p;
  endfunction

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SQUARE_ROW_ZERO:  prdata = {7'd0, square_row[0]};
      REG_SQUARE_ROW_ONE:   prdata = {7'd0, square_row[1]};
      REG_SQUARE_ROW_TWO:   prdata = {7'd0, square_row[2]};
      REG_SQUARE_ROW_THREE: prdata = {7'd0, square_row[3]};
      REG_SQUARE_ROW_FOUR:  prdata = {7'd0, square_row[4]};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) square_row[r] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_SQUARE_ROW_ZERO:  square_row[0] <= pwdata[ROW_WIDTH-1:0];
        REG_SQUARE_ROW_ONE:   square_row[1] <= pwdata[ROW_WIDTH-1:0];
        REG_SQUARE_ROW_TWO:   square_row[2] <= pwdata[ROW_WIDTH-1:0];
        REG_SQUARE_ROW_THREE: square_row[3] <= pwdata[ROW_WIDTH-1:0];
        REG_SQUARE_ROW_FOUR:  square_row[4] <= pwdata[ROW_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign cipher_valid = (buf_len != 3'd0);
  assign cipher_byte  = buf_data[0];
  assign last_of_run  = (buf_len == 3'd1);
  assign cipher_xfer  = cipher_valid && cipher_ready;
  assign buf_free     = (buf_len == 3'd0) || (buf_len == 3'd1 && cipher_ready);
  assign work_move    = work_valid && buf_free;
  assign plain_ready  = !work_valid || buf_free;
  assign plain_xfer   = plain_valid && plain_ready;

  // letter pairing
  always_comb begin
    is_letter = 1'b0;
    letter    = '0;
    if (plain_byte >= ASCII_UPPER_A && plain_byte <= ASCII_UPPER_Z) begin
      is_letter = 1'b1;
      letter    = code_t'(plain_byte - ASCII_UPPER_A);
    end else if (plain_byte >= ASCII_LOWER_A && plain_byte <= ASCII_LOWER_Z) begin
      is_letter = 1'b1;
      letter    = code_t'(plain_byte - ASCII_LOWER_A);
    end
    if (letter == CODE_J) letter = CODE_I;

    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    pair_now         = 1'b0;
    twice_now        = 1'b0;
    first_now        = held_letter;
    second_now       = filler_for(held_letter);
    if (is_letter) begin
      if (!held_valid) begin
        held_letter_next = letter;
        held_valid_next  = 1'b1;
      end else if (held_letter == letter) begin
        pair_now = 1'b1;
      end else begin
        pair_now        = 1'b1;
        second_now      = letter;
        held_valid_next = 1'b0;
      end
    end
    if (end_of_message && held_valid_next) begin
      // a held letter at end of message is paired with a filler; a doubled letter repeats the same pair
      twice_now        = pair_now;
      pair_now         = 1'b1;
      first_now        = held_letter_next;
      second_now       = filler_for(held_letter_next);
      held_valid_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid  <= 1'b0;
    end else if (plain_xfer) begin
      held_letter <= held_letter_next;
      held_valid  <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (plain_xfer) begin
      work_valid <= pair_now;
    end else if (work_move) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (plain_xfer) begin
      work_first  <= first_now;
      work_second <= second_now;
      work_twice  <= twice_now;
    end
  end

  // square lookup
  always_comb begin
    p1 = locate(square_row, work_first);
    p2 = locate(square_row, work_second);
    if (p1.row == p2.row) begin
      o1 = cell_at(square_row, p1.row, inc5(p1.col));
      o2 = cell_at(square_row, p2.row, inc5(p2.col));
    end else if (p1.col == p2.col) begin
      o1 = cell_at(square_row, inc5(p1.row), p1.col);
      o2 = cell_at(square_row, inc5(p2.row), p2.col);
    end else begin
      o1 = cell_at(square_row, p1.row, p2.col);
      o2 = cell_at(square_row, p2.row, p1.col);
    end
  end

  // result buffer, head at entry zero
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len <= '0;
    end else if (work_move) begin
      buf_len <= work_twice ? 3'd4 : 3'd2;
    end else if (cipher_xfer) begin
      buf_len <= buf_len - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (work_move) begin
      buf_data[0] <= to_ascii(o1);
      buf_data[1] <= to_ascii(o2);
      buf_data[2] <= to_ascii(o1);
      buf_data[3] <= to_ascii(o2);
    end else if (cipher_xfer) begin
      buf_data[0] <= buf_data[1];
      buf_data[1] <= buf_data[2];
      buf_data[2] <= buf_data[3];
    end
  end

  assign cipher_in_range = (cipher_byte >= ASCII_LOWER_A[6:0]) &&
                           (cipher_byte <= ASCII_LOWER_Z[6:0]);

  `PFE_NEVER(a_buf_len_range, buf_len > 3'd4, "result buffer length out of range")
  `PFE_NEVER(a_held_not_j, held_valid && held_letter == CODE_J, "held letter is j")
  `PFE_ASSERT(a_move_fills, work_move |=> buf_len != 3'd0, "pair moved but buffer empty")
  `PFE_ASSERT(a_out_lower, cipher_valid |-> cipher_in_range, "cipher byte not lower case")

endmodule
